// ===== design/positional_list_insert_remove_top_defines.svh =====
// Assertion macros for the positional list block and its checker.
// Depends on nothing; the using scope provides clk and rst_n.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional list check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional list check failed");

`endif

// ===== design/plr_pkg.sv =====
// Shared types and constants for the positional list block.
// Depends on nothing.
`default_nettype none
package plr_pkg;

  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_PUT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== design/positional_list_insert_remove_top.sv =====
// An ordered list of up to DEPTH signed 32-bit words held in one RAM, with a
// count. Insert places a word at a position from 0 to count and remove takes
// the word at a position below count; each command returns one result word.
// Entries are moved one at a time through the single RAM read and write port,
// each in a read state and then a write state because the read is registered.
// A finished command waits in S_DONE until the previous result has been taken.
// The block is not ready while a command is in progress, but it accepts a new
// command while a finished result still waits on the output.
// Depends on plr_pkg and plr_ram.
`default_nettype none
module positional_list_insert_remove_top #(
  parameter int DEPTH = plr_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [plr_pkg::POS_W-1:0]           in_position,
  input  logic signed [plr_pkg::VAL_W-1:0]    in_new_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_success,
  output logic signed [plr_pkg::VAL_W-1:0]    out_removed_value,
  output logic [plr_pkg::CNT_OUT_W-1:0]       out_entry_count
);
  import plr_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]     pos_r, pos_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic [VAL_W-1:0]      val_r, val_nxt;
  logic [VAL_W-1:0]      taken_r, taken_nxt;
  logic                  ok_r, ok_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_success_r, out_success_nxt;
  logic [VAL_W-1:0]      out_removed_r, out_removed_nxt;
  logic [CNT_OUT_W-1:0]  out_count_r, out_count_nxt;

  logic                  ram_wr_en;
  logic [ADDR_W-1:0]     ram_wr_addr;
  logic [VAL_W-1:0]      ram_wr_data;
  logic                  ram_rd_en;
  logic [ADDR_W-1:0]     ram_rd_addr;
  logic [VAL_W-1:0]      ram_rd_data;

  logic [CMP_W-1:0]      in_pos_ext, cnt_ext, idx_ext, pos_ext;
  logic                  ins_ok, rem_ok;

  plr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_pos_ext = CMP_W'(in_position);
  assign cnt_ext    = CMP_W'(count_r);
  assign idx_ext    = CMP_W'(idx_r);
  assign pos_ext    = CMP_W'(pos_r);
  assign ins_ok     = (in_pos_ext <= cnt_ext) && (cnt_ext < CMP_W'(DEPTH));
  assign rem_ok     = in_pos_ext < cnt_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    pos_r         <= pos_nxt;
    idx_r         <= idx_nxt;
    val_r         <= val_nxt;
    taken_r       <= taken_nxt;
    ok_r          <= ok_nxt;
    out_success_r <= out_success_nxt;
    out_removed_r <= out_removed_nxt;
    out_count_r   <= out_count_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    pos_nxt         = pos_r;
    idx_nxt         = idx_r;
    val_nxt         = val_r;
    taken_nxt       = taken_r;
    ok_nxt          = ok_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r;
    out_success_nxt = out_success_r;
    out_removed_nxt = out_removed_r;
    out_count_nxt   = out_count_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = idx_r;
    ram_wr_data     = ram_rd_data;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = idx_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_command);
          pos_nxt   = ADDR_W'(in_pos_ext);
          val_nxt   = in_new_value;
          taken_nxt = '0;
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
          if (cmd_t'(in_command) == CMD_INSERT) begin
            if (ins_ok) begin
              ok_nxt    = 1'b1;
              idx_nxt   = ADDR_W'(cnt_ext);
              state_nxt = (cnt_ext > in_pos_ext) ? S_RD : S_PUT;
            end
          end else if (rem_ok) begin
            ok_nxt    = 1'b1;
            idx_nxt   = ADDR_W'(in_pos_ext);
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = (cmd_r == CMD_INSERT) ? idx_r - ADDR_W'(1) : idx_r;
        state_nxt   = S_WR;
      end
      S_WR: begin
        if (cmd_r == CMD_INSERT) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = idx_r;
          idx_nxt     = idx_r - ADDR_W'(1);
          state_nxt   = (idx_ext - CMP_W'(1) > pos_ext) ? S_RD : S_PUT;
        end else begin
          if (idx_r == pos_r) begin
            taken_nxt = ram_rd_data;
          end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_r - ADDR_W'(1);
          end
          if (idx_ext + CMP_W'(1) < cnt_ext) begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = S_RD;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end
      end
      S_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pos_r;
        ram_wr_data = val_r;
        count_nxt   = count_r + CNT_W'(1);
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = ok_r;
          out_removed_nxt = taken_r;
          out_count_nxt   = CNT_OUT_W'(count_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_success       = out_success_r;
  assign out_removed_value = out_removed_r;
  assign out_entry_count   = out_count_r;

endmodule
`default_nettype wire

// ===== design/plr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module plr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/plr_chk.sv =====
// Port-level checker for the positional list block, bound to its top level.
// Uses plr_pkg and the macros in positional_list_insert_remove_top_defines.svh.
`default_nettype none
`include "positional_list_insert_remove_top_defines.svh"
module plr_chk #(
  parameter int DEPTH = plr_pkg::DEPTH_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             out_success,
  input wire logic [plr_pkg::VAL_W-1:0]        out_removed_value,
  input wire logic [plr_pkg::CNT_OUT_W-1:0]    out_entry_count
);

  logic [plr_pkg::VAL_W+plr_pkg::CNT_OUT_W:0] out_word;

  assign out_word = {out_success, out_removed_value, out_entry_count};

  // A waiting result word must not change until it is taken.
  `PLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  // Only a successful remove reports a nonzero value.
  `PLR_ASSERT_SAME(a_fail_zero, out_valid && !out_success, out_removed_value == '0)
  // The reported count never exceeds the list capacity.
  `PLR_ASSERT_SAME(a_count_cap, out_valid, 32'(out_entry_count) <= DEPTH)
  // Accepting a command always leaves the block busy, not ready for another command.
  `PLR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind positional_list_insert_remove_top plr_chk #(.DEPTH(DEPTH)) u_plr_chk (.*);
`default_nettype wire

// ===== tb/positional_list_insert_remove_top_tb.sv =====
// Self-checking testbench for positional_list_insert_remove_top: inserts and removes
// words at random positions, predicts each result word and checks it in order.
// Depends on plr_pkg and the positional list RTL.
`default_nettype none
module positional_list_insert_remove_top_tb;
  import plr_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_WORDS = 1250;

  typedef struct {
    logic                    success;
    logic signed [VAL_W-1:0] removed;
    logic [CNT_OUT_W-1:0]    count;
  } list_result_t;

  class list_scoreboard;
    logic signed [VAL_W-1:0] entries[LIST_DEPTH];
    int unsigned             count;
    list_result_t            expected_q[$];
    int                      errors;
    int                      inserts_done;
    int                      removes_done;
    int                      rejects;
    int                      full_hits;

    function new();
      count = 0;
      errors = 0;
      inserts_done = 0;
      removes_done = 0;
      rejects = 0;
      full_hits = 0;
    endfunction

    function int unsigned held();
      return count;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] error: %s", $time, msg);
    endtask

    function void note_input(cmd_t cmd, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
      list_result_t r;
      int unsigned  i;
      r.success = 1'b0;
      r.removed = '0;
      if (cmd == CMD_INSERT) begin
        if (pos <= count && count < LIST_DEPTH) begin
          for (i = count; i > pos; i--) entries[i] = entries[i-1];
          entries[pos] = val;
          count++;
          r.success = 1'b1;
          inserts_done++;
          if (count == LIST_DEPTH) full_hits++;
        end
      end else begin
        if (pos < count) begin
          r.removed = entries[pos];
          for (i = pos; i + 1 < count; i++) entries[i] = entries[i+1];
          count--;
          r.success = 1'b1;
          removes_done++;
        end
      end
      if (!r.success) rejects++;
      r.count = count[CNT_OUT_W-1:0];
      expected_q.push_back(r);
    endfunction

    task check_result(logic success, logic signed [VAL_W-1:0] removed,
                      logic [CNT_OUT_W-1:0] cnt);
      list_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with nothing expected (success %b count %0d)",
                         success, cnt));
      end else begin
        e = expected_q.pop_front();
        if (success !== e.success)
          report($sformatf("success %b, expected %b", success, e.success));
        if (removed !== e.removed)
          report($sformatf("removed_value %0d, expected %0d", removed, e.removed));
        if (cnt !== e.count)
          report($sformatf("entry_count %0d, expected %0d", cnt, e.count));
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_command;
  logic [POS_W-1:0]           in_position;
  logic signed [VAL_W-1:0]    in_new_value;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_success;
  logic signed [VAL_W-1:0]    out_removed_value;
  logic [CNT_OUT_W-1:0]       out_entry_count;

  list_scoreboard sb = new();
  int             burst_left = 0;

  positional_list_insert_remove_top #(.DEPTH(LIST_DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_new_value      (in_new_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_success       (out_success),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Opens a new burst when the current one is used up, with an optional gap.
  task pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task send_item(cmd_t cmd, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_position  <= pos;
    in_new_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, pos, val);
  endtask

  task send_paced(cmd_t cmd, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
    pace();
    send_item(cmd, pos, val);
  endtask

  task run_directed();
    int k;
    send_paced(CMD_REMOVE, 5'd0, 32'sh1234_5678);
    send_paced(CMD_INSERT, 5'd1, 32'sh0000_0001);
    send_paced(CMD_INSERT, 5'd0, 32'sh8000_0000);
    send_paced(CMD_INSERT, 5'd1, 32'sh7fff_ffff);
    send_paced(CMD_INSERT, 5'd0, -1);
    send_paced(CMD_INSERT, 5'd1, '0);
    send_paced(CMD_REMOVE, 5'd1, '1);
    send_paced(CMD_REMOVE, 5'd2, '0);
    for (k = 0; k < LIST_DEPTH - 2; k++) begin
      send_paced(CMD_INSERT, POS_W'($urandom_range(0, sb.held())), pick_value());
    end
    send_paced(CMD_INSERT, 5'd16, 32'sh5555_aaaa);
    send_paced(CMD_INSERT, 5'd0, 32'shaaaa_5555);
    send_paced(CMD_REMOVE, 5'd31, '0);
    send_paced(CMD_REMOVE, 5'd16, '0);
    send_paced(CMD_REMOVE, 5'd15, '0);
    send_paced(CMD_INSERT, 5'd31, 32'sh0f0f_0f0f);
    send_paced(CMD_REMOVE, 5'd0, '0);
  endtask

  task run_random();
    int               n;
    int unsigned      cnt;
    bit               filling;
    bit               do_insert;
    cmd_t             cmd;
    logic [POS_W-1:0] pos;
    filling = 1'b0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      cnt = sb.held();
      if (cnt == LIST_DEPTH) filling = 1'b0;
      else if (cnt == 0) filling = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        cmd = cmd_t'($urandom_range(0, 1));
        pos = POS_W'($urandom_range(0, 31));
      end else begin
        do_insert = filling ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
        if (cnt == 0) do_insert = 1'b1;
        if (cnt == LIST_DEPTH) do_insert = ($urandom_range(0, 7) == 0);
        if (do_insert) begin
          cmd = CMD_INSERT;
          pos = POS_W'($urandom_range(0, cnt));
        end else begin
          cmd = CMD_REMOVE;
          pos = POS_W'($urandom_range(0, cnt - 1));
        end
      end
      send_paced(cmd, pos, pick_value());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_success, out_removed_value, out_entry_count);
    end
  end

  initial begin
    int mode;
    int len;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(5, 60);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= CMD_INSERT;
    in_position  <= '0;
    in_new_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LIST_DEPTH + 8) @(posedge clk);
    $display("Ran %0d inserts and %0d removes that succeeded and %0d rejected commands.",
             sb.inserts_done, sb.removes_done, sb.rejects);
    $display("The list filled to %0d entries %0d times.", LIST_DEPTH, sb.full_hits);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d result words still expected.", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
